@@ rtl/core/sparse_accumulator_table_defines.svh @@
// ----------------------------------------------------------------------------
// Sparse accumulator table assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ACCUMULATOR_TABLE_DEFINES_SVH
`define SPARSE_ACCUMULATOR_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition holds at every clock edge outside reset.
`define SAT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sparse accumulator table: invariant violated");

// Checks that a condition in one cycle implies a consequence in the next.
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse accumulator table: sequence violated");

`else

`define SAT_ASSERT_ALWAYS(lbl, cond)
`define SAT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse accumulator table package
// Command codes and fixed field widths of the stream payloads.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Fixed payload field widths.
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_OUT_W = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 40;

  // Command codes; the unused codes behave as a read.
  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_ADD     = 3'd2,
    CMD_PREINC  = 3'd3,
    CMD_POSTINC = 3'd4
  } cmd_e;

endpackage

@@ rtl/core/sat_ram.sv @@
// ----------------------------------------------------------------------------
// Sparse accumulator table RAM
// Simple dual-port memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; contents are undefined until written.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sparse_accumulator_table.sv @@
// ----------------------------------------------------------------------------
// Sparse accumulator table
// Bounded key/value map that keeps only entries with a nonzero value.
// ----------------------------------------------------------------------------
// Usage: each transaction on the slave stream carries a command, a key and an
// operand; the block answers with exactly one transaction on the master
// stream carrying the result value, the entry count and the full flag.
// The key is searched by a sequencer that reads one slot of the key RAM per
// cycle and compares it against the request with one shared comparator; the
// value is then fetched, updated by one shared 32-bit adder and written back.
// Path from input transaction to result valid: a hit passes ST_SCAN, ST_VAL,
// ST_CALC and ST_DONE; a miss scans every slot and skips ST_VAL.
// Only one item is in flight: s_axis_tready is high only while the sequencer
// is idle, and the next item may be taken while a result still waits in the
// output register. If the receiver stalls, the result is held in the output
// register and a following item completes its update but waits before
// delivering its own result.
// Reset clears all valid bits and the entry count at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "sparse_accumulator_table_defines.svh"

module sparse_accumulator_table
  import sat_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0 up: command[2:0], key[34:3], operand[66:35], zero fill.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0 up: result_value[31:0], entry_count[36:32],
  // table_full[37], zero fill.
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VAL,
    ST_CALC,
    ST_DONE
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic [DATA_W-1:0]   key_q;
  logic [DATA_W-1:0]   opd_q;
  logic [IW-1:0]       addr_q;
  logic [IW-1:0]       chk_idx_q;
  logic                chk_pend_q;
  logic [IW-1:0]       slot_q;
  logic                present_q;
  logic [IW-1:0]       free_q;
  logic                free_fnd_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CW-1:0]       count_q;
  logic [DATA_W-1:0]   res_q;
  logic                full_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic                m_tvalid_q;

  logic [DATA_W-1:0]   key_rd;
  logic [DATA_W-1:0]   val_rd;

  // RAM write port, driven in the update cycle.
  logic                key_we;
  logic                val_we;
  logic [IW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_val;

  // Update datapath signals.
  logic                hit;
  logic                free_now;
  logic [IW-1:0]       free_idx;
  logic [DATA_W-1:0]   old_val;
  logic [DATA_W-1:0]   addend;
  logic [DATA_W-1:0]   sum;
  logic [DATA_W-1:0]   next_val;
  logic [DATA_W-1:0]   res_val;
  logic                modify;
  logic                do_remove;
  logic                do_update;
  logic                do_insert;
  logic                ins_fail;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // Key and value memories.
  sat_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (key_q),
    .raddr_i (addr_q),
    .rdata_o (key_rd)
  );

  sat_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_val),
    .raddr_i (slot_q),
    .rdata_o (val_rd)
  );

  // Search compare and lowest-free-slot tracking for the slot under check.
  assign hit      = chk_pend_q && valid_q[chk_idx_q] && (key_rd == key_q);
  assign free_now = free_fnd_q || !valid_q[chk_idx_q];
  assign free_idx = free_fnd_q ? free_q : chk_idx_q;

  // Shared adder and command decode; an absent key starts from zero.
  always_comb begin
    old_val  = present_q ? val_rd : '0;
    addend   = (cmd_q == CMD_ADD) ? opd_q : DATA_W'(1);
    sum      = old_val + addend;
    next_val = old_val;
    res_val  = old_val;
    modify   = 1'b1;
    case (cmd_q)
      CMD_WRITE: begin
        next_val = opd_q;
        res_val  = opd_q;
      end
      CMD_ADD, CMD_PREINC: begin
        next_val = sum;
        res_val  = sum;
      end
      CMD_POSTINC: begin
        next_val = sum;
        res_val  = old_val;
      end
      default: begin
        modify = 1'b0;
      end
    endcase
  end

  // Update decisions, valid only in the calculation cycle.
  always_comb begin
    do_remove = (state_q == ST_CALC) && modify && present_q && (next_val == '0);
    do_update = (state_q == ST_CALC) && modify && present_q && (next_val != '0);
    do_insert = (state_q == ST_CALC) && modify && !present_q && (next_val != '0)
                && free_fnd_q;
    ins_fail  = (state_q == ST_CALC) && modify && !present_q && (next_val != '0)
                && !free_fnd_q;
    key_we    = do_insert;
    val_we    = do_update || do_insert;
    wr_addr   = present_q ? slot_q : free_q;
    wr_val    = next_val;
  end

  // Entry count carried in the low bits of the output field.
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_q};

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= CMD_READ;
      key_q      <= '0;
      opd_q      <= '0;
      addr_q     <= '0;
      chk_idx_q  <= '0;
      chk_pend_q <= 1'b0;
      slot_q     <= '0;
      present_q  <= 1'b0;
      free_q     <= '0;
      free_fnd_q <= 1'b0;
      valid_q    <= '0;
      count_q    <= '0;
      res_q      <= '0;
      full_q     <= 1'b0;
      m_tdata_q  <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      // The receiver takes the held result; in the final state a new result
      // may take its place in the same cycle.
      if (m_tvalid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q      <= cmd_e'(s_axis_tdata[2:0]);
            key_q      <= s_axis_tdata[34:3];
            opd_q      <= s_axis_tdata[66:35];
            addr_q     <= '0;
            chk_pend_q <= 1'b0;
            present_q  <= 1'b0;
            free_fnd_q <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end

        // One slot is read and one slot compared per cycle.
        ST_SCAN: begin
          if (hit) begin
            slot_q    <= chk_idx_q;
            present_q <= 1'b1;
            state_q   <= ST_VAL;
          end else begin
            if (chk_pend_q) begin
              free_q     <= free_idx;
              free_fnd_q <= free_now;
            end
            if (chk_pend_q && (chk_idx_q == LAST_IDX)) begin
              state_q <= ST_CALC;
            end else begin
              chk_idx_q  <= addr_q;
              chk_pend_q <= 1'b1;
              addr_q     <= addr_q + IW'(1);
            end
          end
        end

        // Value RAM read of the hit slot.
        ST_VAL: begin
          state_q <= ST_CALC;
        end

        ST_CALC: begin
          if (do_remove) begin
            valid_q[slot_q] <= 1'b0;
            count_q         <= count_q - CW'(1);
          end
          if (do_insert) begin
            valid_q[free_q] <= 1'b1;
            count_q         <= count_q + CW'(1);
          end
          res_q   <= res_val;
          full_q  <= ins_fail;
          state_q <= ST_DONE;
        end

        // Load the output register once it is free.
        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tdata_q  <= {2'b00, full_q, cnt_ext[CNT_OUT_W-1:0], res_q};
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The entry count always equals the number of valid slots.
  `SAT_ASSERT_ALWAYS(a_count_matches_valid, count_q == CW'($countones(valid_q)))

  // The entry count never exceeds the capacity.
  `SAT_ASSERT_ALWAYS(a_count_bounded, count_q <= CW'(CAPACITY))

  // After an input transaction the block is busy searching.
  `SAT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A failed insert leaves a completely occupied table.
  `SAT_ASSERT_NEXT(a_full_only_when_full, ins_fail, count_q == CW'(CAPACITY))

endmodule

@@ test/sparse_accumulator_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse accumulator table checker
// Watches both stream channels of the table. Every accepted command is applied
// to a local copy of the key/value table to predict its reply, and every
// accepted reply is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_accumulator_table_checker
  import sat_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0 up: command[2:0], key[34:3], operand[66:35], zero fill.
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // Fields from bit 0 up: result_value[31:0], entry_count[36:32],
  // table_full[37], zero fill.
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic [CNT_OUT_W-1:0] count;
    logic                 full;
  } table_reply_t;

  // Local copy of the table contents.
  logic [DATA_W-1:0] slot_key  [CAPACITY];
  logic [DATA_W-1:0] slot_val  [CAPACITY];
  logic              slot_used [CAPACITY];
  int unsigned       held_entries;

  table_reply_t table_replies_q[$];
  int unsigned  replies_owed;
  int unsigned  mismatch_count;

  assign pending_o = replies_owed;
  assign errors_o  = mismatch_count;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Applies one command to the local table and returns the reply it causes.
  function automatic table_reply_t apply_table_command(input logic [CMD_W-1:0] cmd,
                                                       input logic [DATA_W-1:0] key,
                                                       input logic [DATA_W-1:0] opd);
    table_reply_t      reply;
    int                hit;
    int                spare;
    logic [DATA_W-1:0] old_val;
    logic [DATA_W-1:0] new_val;
    logic              changes;
    hit   = -1;
    spare = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && spare < 0) spare = i;
    end
    old_val     = (hit >= 0) ? slot_val[hit] : '0;
    new_val     = old_val;
    reply.value = old_val;
    reply.full  = 1'b0;
    changes     = 1'b1;
    case (cmd)
      CMD_WRITE: begin
        new_val     = opd;
        reply.value = opd;
      end
      CMD_ADD: begin
        new_val     = old_val + opd;
        reply.value = new_val;
      end
      CMD_PREINC: begin
        new_val     = old_val + 1'b1;
        reply.value = new_val;
      end
      CMD_POSTINC: begin
        new_val     = old_val + 1'b1;
        reply.value = old_val;
      end
      // Read and the unused codes leave the table alone.
      default: changes = 1'b0;
    endcase
    if (changes) begin
      if (hit >= 0) begin
        // A value that drops to zero removes its entry.
        if (new_val == '0) begin
          slot_used[hit] = 1'b0;
          held_entries--;
        end else begin
          slot_val[hit] = new_val;
        end
      end else if (new_val != '0) begin
        if (spare >= 0) begin
          slot_used[spare] = 1'b1;
          slot_key[spare]  = key;
          slot_val[spare]  = new_val;
          held_entries++;
        end else begin
          reply.full = 1'b1;
        end
      end
    end
    reply.count = held_entries[CNT_OUT_W-1:0];
    return reply;
  endfunction

  // Replies are popped before commands are pushed: a reply accepted in the
  // same cycle as a command always belongs to an earlier command.
  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      held_entries = 0;
      table_replies_q.delete();
      replies_owed   = 0;
      mismatch_count = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (table_replies_q.size() == 0) begin
          report_mismatch("reply with no command waiting", m_tdata_i[31:0], '0);
        end else begin
          want = table_replies_q.pop_front();
          if (m_tdata_i[31:0] !== want.value)
            report_mismatch("result_value", m_tdata_i[31:0], want.value);
          if (m_tdata_i[36:32] !== want.count)
            report_mismatch("entry_count", DATA_W'(m_tdata_i[36:32]), DATA_W'(want.count));
          if (m_tdata_i[37] !== want.full)
            report_mismatch("table_full", DATA_W'(m_tdata_i[37]), DATA_W'(want.full));
        end
      end
      if (s_tvalid_i && s_tready_i)
        table_replies_q.push_back(apply_table_command(s_tdata_i[2:0], s_tdata_i[34:3],
                                                      s_tdata_i[66:35]));
      replies_owed = table_replies_q.size();
    end
  end

endmodule

@@ test/sparse_accumulator_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse accumulator table testbench
// Drives directed corner commands, a table fill past capacity, and then random
// episodes of commands on small key pools, each drained back to an empty
// table. Both stream sides idle at random; a separate checker predicts and
// compares every reply.
// ----------------------------------------------------------------------------
module sparse_accumulator_table_tb;
  import sat_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned STALL_LIMIT = 4000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  // Fields from bit 0 up: command[2:0], key[34:3], operand[66:35], zero fill.
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // Fields from bit 0 up: result_value[31:0], entry_count[36:32],
  // table_full[37], zero fill.
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  int unsigned replies_owed;
  int unsigned error_count;
  int unsigned commands_sent = 0;
  int unsigned quiet_cycles  = 0;
  logic        no_gaps       = 1'b0;

  always #6 clk_i = ~clk_i;

  sparse_accumulator_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  sparse_accumulator_table_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .pending_o (replies_owed),
    .errors_o  (error_count)
  );

  // Sends one command transaction; valid stays high afterwards unless the
  // next call draws a gap or await_idle_table drops it.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] opd);
    int unsigned gap;
    logic        took;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'b0, opd, key, cmd};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    commands_sent++;
  endtask

  // Holds the command stream until every reply has been delivered.
  task automatic await_idle_table();
    logic idle;
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk_i);
      idle = (replies_owed == 0);
      @(posedge clk_i);
    end while (!idle);
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return CMD_READ;
    if (roll < 40) return CMD_WRITE;
    if (roll < 60) return CMD_ADD;
    if (roll < 75) return CMD_PREINC;
    if (roll < 93) return CMD_POSTINC;
    return CMD_W'($urandom_range(5, 7));
  endfunction

  // Reply side: a random stall before each reply, or none in gap-free episodes.
  initial begin
    int unsigned stall;
    logic        took;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL sparse_accumulator_table");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [DATA_W-1:0] pool [24];
    int unsigned       pool_size;
    int unsigned       episode_len;
    int unsigned       episode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, wrap-around, removal and the unused codes.
    issue_command(CMD_READ, 32'h8000_0000, 32'hffff_ffff);
    issue_command(CMD_WRITE, 32'h7fff_ffff, 32'h8000_0000);
    issue_command(CMD_READ, 32'h7fff_ffff, 32'h0);
    issue_command(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000);
    issue_command(CMD_WRITE, 32'h0, 32'h0);
    issue_command(CMD_PREINC, 32'h0, 32'h5555_aaaa);
    issue_command(CMD_POSTINC, 32'h0, 32'haaaa_5555);
    issue_command(CMD_WRITE, 32'hffff_ffff, 32'hffff_ffff);
    issue_command(CMD_PREINC, 32'hffff_ffff, 32'h0);
    issue_command(CMD_ADD, 32'h5, 32'h7fff_ffff);
    issue_command(CMD_ADD, 32'h5, 32'h1);
    issue_command(CMD_W'(5), 32'h5, 32'h0);
    issue_command(CMD_W'(6), 32'h5, 32'h0);
    issue_command(CMD_W'(7), 32'h5, 32'h0);
    issue_command(CMD_WRITE, 32'h5, 32'hffff_ffff);
    issue_command(CMD_POSTINC, 32'h5, 32'h0);

    // Fill the table, then try inserts that no longer fit.
    for (int i = 1; i < CAPACITY; i++) issue_command(CMD_WRITE, 32'h100 + i, $urandom | 1);
    issue_command(CMD_WRITE, 32'h8000_0000, 32'h1234_5678);
    issue_command(CMD_PREINC, 32'h8000_0000, 32'h0);
    issue_command(CMD_ADD, 32'h8000_0000, 32'h0);
    issue_command(CMD_WRITE, 32'h0, 32'h0);
    issue_command(CMD_WRITE, 32'h8000_0000, 32'h1);
    for (int i = 1; i < CAPACITY; i++) issue_command(CMD_WRITE, 32'h100 + i, 32'h0);
    issue_command(CMD_WRITE, 32'h8000_0000, 32'h0);
    await_idle_table();

    // Random episodes on a key pool, each emptied again at its end. Pools
    // larger than the capacity run into the full table.
    episode = 0;
    while (commands_sent < ITEM_TARGET) begin
      no_gaps     = ($urandom_range(0, 3) == 0);
      pool_size   = $urandom_range(1, 24);
      episode_len = $urandom_range(8, 40);
      for (int i = 0; i < pool_size; i++) pool[i] = pick_key();
      for (int n = 0; n < episode_len; n++)
        issue_command(pick_command(), pool[$urandom_range(0, pool_size - 1)], pick_operand());
      for (int i = 0; i < pool_size; i++) issue_command(CMD_WRITE, pool[i], 32'h0);
      episode++;
      if (episode % 5 == 0) await_idle_table();
    end

    await_idle_table();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS sparse_accumulator_table");
    end else begin
      $display("FAIL sparse_accumulator_table");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sparse_accumulator_table.sv
test/sparse_accumulator_table_checker.sv
test/sparse_accumulator_table_tb.sv
